### design/ckw_pkg.sv
// Shared types, constants and byte-class helpers for the C keyword token counter.
// No dependencies; imported by ckw_dp, ckw_ctrl and c_keyword_token_counter.
package ckw_pkg;

	localparam int MAX_TOKEN    = 100;
	localparam int NUM_KEYWORDS = 16;
	localparam int COUNT_WIDTH  = 32;
	localparam int LEN_W        = 7;
	localparam int PTR_W        = $clog2(NUM_KEYWORDS);
	localparam int HIT_W        = 32;
	localparam int KW_CHARS     = 8;
	localparam int KW_LEN_W     = 4;

	typedef logic [LEN_W-1:0]        len_t;
	typedef logic [NUM_KEYWORDS-1:0] kw_mask_t;
	typedef logic [COUNT_WIDTH-1:0]  cnt_t;
	typedef logic [PTR_W-1:0]        ptr_t;

	// keyword text, right-aligned: first character in the highest used byte
	localparam logic [KW_CHARS*8-1:0] KW_TEXT [NUM_KEYWORDS] = '{
		64'("#define"),  64'("#if"),      64'("#ifdef"),  64'("#ifndef"),
		64'("#include"), 64'("auto"),     64'("break"),   64'("case"),
		64'("char"),     64'("const"),    64'("continue"), 64'("default"),
		64'("unsigned"), 64'("void"),     64'("volatile"), 64'("while")
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd7, 4'd3, 4'd6, 4'd7, 4'd8, 4'd4, 4'd5, 4'd4,
		4'd4, 4'd5, 4'd8, 4'd7, 4'd8, 4'd4, 4'd8, 4'd5
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_REPORT
	} ckw_state_t;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_mark;
	} ckw_in_t;

	typedef struct packed {
		logic [3:0]       keyword_index;
		logic [HIT_W-1:0] hit_count;
		logic             has_entry;
		logic             last_of_report;
	} ckw_out_t;

	// controller to datapath
	typedef struct packed {
		logic byte_en;   // take source byte into the tokenizer
		logic end_en;    // close any open token
		logic step;      // report walk advances, clears counter at ptr
		logic load_out;  // load the output word register
		ptr_t ptr;
		logic out_has;
		logic out_last;
	} ckw_cmd_t;

	// datapath to controller
	typedef struct packed {
		kw_mask_t nz;    // counter holds a nonzero value
	} ckw_sts_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_mark(input logic [7:0] b);
		return b == 8'h23 || b == 8'h2A || b == 8'h2F || b == 8'h27 ||
			b == 8'h22 || b == 8'h5C || b == 8'h5F;
	endfunction

	// keyword k has byte b at position pos
	function automatic logic kw_match(input int k, input len_t pos, input logic [7:0] b);
		logic [KW_LEN_W-1:0] n;
		logic [2:0]          sh;
		logic [7:0]          c;
		n  = KW_LEN[k];
		sh = 3'(n - 4'd1 - pos[KW_LEN_W-1:0]);
		c  = KW_TEXT[k][{sh, 3'b000} +: 8];
		return (len_t'(n) > pos) && (c == b);
	endfunction

endpackage

### design/ckw_dp.sv
// Datapath: tokenizer with keyword candidate mask, sixteen saturating counters,
// output word register. Depends on ckw_pkg.
module ckw_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ckw_pkg::ckw_in_t  src_data,
	input  ckw_pkg::ckw_cmd_t cmd,
	output ckw_pkg::ckw_sts_t sts,
	output ckw_pkg::ckw_out_t rpt_data
);
	import ckw_pkg::*;

	logic     in_token_q;
	len_t     tok_len_q;
	kw_mask_t cand_q;
	kw_mask_t hit_q;
	cnt_t     counts_q [NUM_KEYWORDS];
	ckw_out_t out_q;

	logic       [7:0] b;
	logic             tok_char, start_char, cont, append, full;
	logic             close_old, close_new;
	kw_mask_t         base_cand, app_cand, hit_d;
	len_t             base_len, app_len;
	cnt_t             sel_cnt;
	logic      [63:0] wide_cnt;
	logic [HIT_W-1:0] sat_cnt;

	// byte classification and candidate filtering
	always_comb begin
		b          = src_data.source_byte;
		tok_char   = is_letter(b) || is_digit(b) || is_mark(b);
		start_char = is_letter(b) || is_mark(b);
		cont       = in_token_q && tok_char;
		append     = cont || start_char;
		base_cand  = cont ? cand_q : '1;
		base_len   = cont ? tok_len_q : '0;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			app_cand[k] = base_cand[k] && kw_match(k, base_len, b);
		end
		app_len   = base_len + len_t'(1);
		full      = app_len >= len_t'(MAX_TOKEN);
		close_old = in_token_q && ((cmd.byte_en && !tok_char) || cmd.end_en);
		close_new = cmd.byte_en && append && full;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			if (close_old) begin
				hit_d[k] = cand_q[k] && (tok_len_q == len_t'(KW_LEN[k]));
			end else if (close_new) begin
				hit_d[k] = app_cand[k] && (app_len == len_t'(KW_LEN[k]));
			end else begin
				hit_d[k] = 1'b0;
			end
		end
	end

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q <= 1'b0;
			tok_len_q  <= '0;
			cand_q     <= '0;
			hit_q      <= '0;
		end else begin
			hit_q <= hit_d;
			if (cmd.end_en || (cmd.byte_en && !(append && !full))) begin
				in_token_q <= 1'b0;
				tok_len_q  <= '0;
				cand_q     <= '0;
			end else if (cmd.byte_en) begin
				in_token_q <= 1'b1;
				tok_len_q  <= app_len;
				cand_q     <= app_cand;
			end
		end
	end

	// counters: bump on a registered hit, cleared as the report walks past
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				counts_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				if (cmd.step && (cmd.ptr == ptr_t'(k))) begin
					counts_q[k] <= '0;
				end else if (hit_q[k] && (counts_q[k] != '1)) begin
					counts_q[k] <= counts_q[k] + cnt_t'(1);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			sts.nz[k] = |counts_q[k];
		end
	end

	// reported count clamps to the output field
	always_comb begin
		sel_cnt  = counts_q[cmd.ptr];
		wide_cnt = 64'(sel_cnt);
		sat_cnt  = (wide_cnt > 64'h0000_0000_FFFF_FFFF) ? '1 : wide_cnt[HIT_W-1:0];
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.keyword_index  <= cmd.out_has ? 4'(cmd.ptr) : '0;
			out_q.hit_count      <= cmd.out_has ? sat_cnt : '0;
			out_q.has_entry      <= cmd.out_has;
			out_q.last_of_report <= cmd.out_last;
		end
	end

	assign rpt_data = out_q;

endmodule

### design/ckw_ctrl.sv
// Controller: input handshake, report walk sequencing, output valid flag.
// Depends on ckw_pkg.
module ckw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	input  logic              src_end,
	output logic              src_ready,
	output logic              rpt_valid,
	input  logic              rpt_ready,
	input  ckw_pkg::ckw_sts_t sts,
	output ckw_pkg::ckw_cmd_t cmd
);
	import ckw_pkg::*;

	ckw_state_t state_q, state_d;
	ptr_t       ptr_q, ptr_d;
	logic       emitted_q, emitted_d;
	logic       out_valid_q, out_valid_d;

	logic     acc, slot_free, here, rest, empty;
	kw_mask_t upper;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			emitted_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			emitted_q   <= emitted_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		src_ready = (state_q == ST_IDLE);
		acc       = src_valid && src_ready;
		slot_free = !out_valid_q || rpt_ready;
		upper     = sts.nz >> ptr_q;
		here      = upper[0];
		rest      = |upper[NUM_KEYWORDS-1:1];
		empty     = (ptr_q == ptr_t'(NUM_KEYWORDS - 1)) && !here && !emitted_q;

		state_d      = state_q;
		ptr_d        = ptr_q;
		emitted_d    = emitted_q;
		cmd          = '0;
		cmd.byte_en  = acc && !src_end;
		cmd.end_en   = acc && src_end;
		cmd.ptr      = ptr_q;
		cmd.out_has  = here;
		cmd.out_last = here ? !rest : 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd.end_en) begin
					state_d = ST_SETTLE;
				end
			end
			// last counter bump lands here
			ST_SETTLE: begin
				ptr_d     = '0;
				emitted_d = 1'b0;
				state_d   = ST_REPORT;
			end
			ST_REPORT: begin
				if (slot_free) begin
					cmd.step     = 1'b1;
					cmd.load_out = here || empty;
					emitted_d    = emitted_q || here;
					ptr_d        = ptr_q + ptr_t'(1);
					if (ptr_q == ptr_t'(NUM_KEYWORDS - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (rpt_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign rpt_valid = out_valid_q;

endmodule

### design/c_keyword_token_counter.sv
// Top level of the C keyword token counter: joins ckw_ctrl and ckw_dp.
// Depends on ckw_pkg, ckw_ctrl, ckw_dp.

// Source bytes are taken one word per clock while idle: tokenizing and keyword
// matching keep a candidate mask per token, and a finished keyword registers a
// hit that then bumps its 32-bit saturating counter. A word with end_mark set
// closes any open token and starts a report: a settle state, then a walk over
// the sixteen counters at one per cycle while the report side does not stall,
// emitting a word per nonzero counter in table order, or a single empty word,
// and clearing each counter as it passes. src_ready is low in settle and walk;
// the report output register lets the last word wait while bytes flow again.
module c_keyword_token_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  ckw_pkg::ckw_in_t  src_data,
	output logic              rpt_valid,
	input  logic              rpt_ready,
	output ckw_pkg::ckw_out_t rpt_data
);
	import ckw_pkg::*;

	ckw_cmd_t cmd;
	ckw_sts_t sts;

	ckw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_end   (src_data.end_mark),
		.src_ready (src_ready),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ckw_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_data (src_data),
		.cmd      (cmd),
		.sts      (sts),
		.rpt_data (rpt_data)
	);

`ifndef SYNTHESIS
	// an empty report word is always the only and last word
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_data.has_entry |->
		rpt_data.last_of_report && rpt_data.hit_count == '0 &&
		rpt_data.keyword_index == '0)
		else $error("empty report word malformed");

	// a keyword word never reports a zero count
	a_entry_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_data.has_entry |-> rpt_data.hit_count != '0)
		else $error("keyword word with zero count");

	// input stalls after an end mark is taken
	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready && src_data.end_mark |=> !src_ready)
		else $error("input taken during report");
`endif

endmodule
